[src/quic_varint_codec_unit_assert.svh]
// assertion macros for the quic varint codec
`ifndef QUIC_VARINT_CODEC_UNIT_ASSERT_SVH
`define QUIC_VARINT_CODEC_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define QVC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define QVC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define QVC_ASSERT(name, prop, msg)
`define QVC_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

[src/qvc_pkg.sv]
// shared types, constants and helpers of the quic varint codec
`default_nettype none

package qvc_pkg;

  localparam int unsigned QVC_QUEUE_DEPTH = 2;
  localparam int unsigned IN_TDATA_W      = 72;
  localparam int unsigned OUT_TDATA_W     = 80;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  len;
    logic [63:0] word;
  } job_t;

  function automatic logic [3:0] code_to_bytes(input logic [1:0] code);
    logic [3:0] n;
    unique case (code)
      2'd0: n = 4'd1;
      2'd1: n = 4'd2;
      2'd2: n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[src/qvc_front.sv]
// front end: accepts requests, runs the byte decoder and builds jobs
`default_nettype none

module qvc_front
  import qvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic        func_i,
  input  wire logic [63:0] value_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        end_i,
  input  wire logic        full_i,
  output logic             push_o,
  output job_t             job_o
);

  logic        dec_active_q, dec_active_d;
  logic [2:0]  dec_rem_q, dec_rem_d;
  logic [1:0]  dec_len_q, dec_len_d;
  logic [61:0] dec_acc_q, dec_acc_d;

  logic        accept;
  logic [1:0]  len_c;
  logic [2:0]  rem_c;
  logic [61:0] acc_c;
  logic [1:0]  enc_code;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && !full_i;

  // encode length code
  always_comb begin
    priority if (value_i[61:6] == '0) begin
      enc_code = 2'd0;
    end else if (value_i[61:14] == '0) begin
      enc_code = 2'd1;
    end else if (value_i[61:30] == '0) begin
      enc_code = 2'd2;
    end else begin
      enc_code = 2'd3;
    end
  end

  always_comb begin
    if (!dec_active_q) begin
      len_c = byte_i[7:6];
      acc_c = {56'd0, byte_i[5:0]};
      rem_c = 3'(code_to_bytes(byte_i[7:6]) - 4'd1);
    end else begin
      len_c = dec_len_q;
      acc_c = {dec_acc_q[53:0], byte_i};
      rem_c = dec_rem_q - 3'd1;
    end
  end

  always_comb begin
    dec_active_d = dec_active_q;
    dec_rem_d    = dec_rem_q;
    dec_len_d    = dec_len_q;
    dec_acc_d    = dec_acc_q;
    push_o       = 1'b0;
    job_o.kind   = KIND_ERROR;
    job_o.len    = 4'd0;
    job_o.word   = 64'd0;
    if (accept) begin
      if (func_i == FUNC_ENCODE) begin
        push_o = 1'b1;
        if (value_i[63:62] != 2'b00) begin
          job_o.kind = KIND_ERROR;
        end else begin
          job_o.kind = KIND_BYTE;
          job_o.len  = code_to_bytes(enc_code);
          unique case (enc_code)
            2'd0: job_o.word = {2'b00, value_i[5:0], 56'd0};
            2'd1: job_o.word = {2'b01, value_i[13:0], 48'd0};
            2'd2: job_o.word = {2'b10, value_i[29:0], 32'd0};
            default: job_o.word = {2'b11, value_i[61:0]};
          endcase
        end
      end else begin
        if (rem_c == 3'd0) begin
          push_o       = 1'b1;
          job_o.kind   = KIND_VALUE;
          job_o.len    = code_to_bytes(len_c);
          job_o.word   = {2'b00, acc_c};
          dec_active_d = 1'b0;
          dec_rem_d    = 3'd0;
          dec_len_d    = 2'd0;
        end else if (end_i) begin
          push_o       = 1'b1;
          job_o.kind   = KIND_ERROR;
          dec_active_d = 1'b0;
          dec_rem_d    = 3'd0;
          dec_len_d    = 2'd0;
        end else begin
          dec_active_d = 1'b1;
          dec_rem_d    = rem_c;
          dec_len_d    = len_c;
          dec_acc_d    = acc_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_active_q <= 1'b0;
      dec_rem_q    <= 3'd0;
      dec_len_q    <= 2'd0;
    end else begin
      dec_active_q <= dec_active_d;
      dec_rem_q    <= dec_rem_d;
      dec_len_q    <= dec_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_acc_q <= dec_acc_d;
  end

endmodule

`default_nettype wire

[src/qvc_fifo.sv]
// job queue between front and back end
`default_nettype none

`include "quic_varint_codec_unit_assert.svh"

module qvc_fifo
  import qvc_pkg::*;
#(
  parameter int unsigned Depth = QVC_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_data_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `QVC_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full job queue")

endmodule

`default_nettype wire

[src/qvc_back.sv]
// back end: serializes jobs into results and holds the output register
`default_nettype none

`include "quic_varint_codec_unit_assert.svh"

module qvc_back
  import qvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output kind_e            kind_o,
  output logic [7:0]       byte_o,
  output logic [61:0]      value_o,
  output logic [3:0]       len_o,
  output logic             last_o
);

  logic        act_q, act_d;
  kind_e       kind_q, kind_d;
  logic [3:0]  len_q, len_d;
  logic [3:0]  rem_q, rem_d;
  logic [63:0] word_q, word_d;

  logic        m_valid_q, m_valid_d;
  kind_e       o_kind_q, o_kind_d;
  logic [7:0]  o_byte_q, o_byte_d;
  logic [61:0] o_value_q, o_value_d;
  logic [3:0]  o_len_q, o_len_d;
  logic        o_last_q, o_last_d;

  logic out_free, emit, fin;

  assign out_free = !m_valid_q || m_ready_i;
  assign emit     = act_q && out_free;
  assign fin      = emit && (rem_q == 4'd1);
  assign pop_o    = job_valid_i && (!act_q || fin);

  always_comb begin
    act_d  = act_q;
    kind_d = kind_q;
    len_d  = len_q;
    rem_d  = rem_q;
    word_d = word_q;
    if (emit) begin
      rem_d  = rem_q - 4'd1;
      word_d = {word_q[55:0], 8'd0};
      if (fin) begin
        act_d = 1'b0;
      end
    end
    if (pop_o) begin
      act_d  = 1'b1;
      kind_d = job_i.kind;
      len_d  = job_i.len;
      rem_d  = (job_i.kind == KIND_BYTE) ? job_i.len : 4'd1;
      word_d = job_i.word;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    o_kind_d  = o_kind_q;
    o_byte_d  = o_byte_q;
    o_value_d = o_value_q;
    o_len_d   = o_len_q;
    o_last_d  = o_last_q;
    if (emit) begin
      m_valid_d = 1'b1;
      o_kind_d  = kind_q;
      o_last_d  = (rem_q == 4'd1);
      unique case (kind_q)
        KIND_BYTE: begin
          o_byte_d  = word_q[63:56];
          o_value_d = 62'd0;
          o_len_d   = len_q;
        end
        KIND_VALUE: begin
          o_byte_d  = 8'd0;
          o_value_d = word_q[61:0];
          o_len_d   = len_q;
        end
        default: begin
          o_byte_d  = 8'd0;
          o_value_d = 62'd0;
          o_len_d   = 4'd0;
        end
      endcase
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      rem_q     <= 4'd0;
      m_valid_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    len_q     <= len_d;
    word_q    <= word_d;
    o_kind_q  <= o_kind_d;
    o_byte_q  <= o_byte_d;
    o_value_q <= o_value_d;
    o_len_q   <= o_len_d;
    o_last_q  <= o_last_d;
  end

  assign m_valid_o = m_valid_q;
  assign kind_o    = o_kind_q;
  assign byte_o    = o_byte_q;
  assign value_o   = o_value_q;
  assign len_o     = o_len_q;
  assign last_o    = o_last_q;

  `QVC_ASSERT(a_idle_takes_job, (job_valid_i && !act_q) |-> pop_o,
              "back end idle while a job waits")
  `QVC_ASSERT(a_rem_nonzero, act_q |-> (rem_q != 4'd0),
              "active job with no bytes left")
  `QVC_ASSERT_NEXT(a_finish_marks_last, fin, (m_valid_q && o_last_q),
                   "final result of a job not marked last")

endmodule

`default_nettype wire

[src/quic_varint_codec_unit.sv]
// top level of the quic variable-length integer codec
//
//  channel   dir  tdata bits (low first)                       tuser  tlast
//  s_axis    in   value_in[63:0] byte_in[71:64]                func   buffer_end
//  m_axis    out  byte_out[7:0] value_out[69:8] length[73:70]  kind   last
//
// decode: one byte request per cycle unless the queue is full, at most one result per byte
// encode: 1, 2, 4 or 8 bytes per valid request, one output byte per cycle unless stalled
// the job queue lets requests enter while the back end still serializes
// reset clears decoder state, queue and output register; no clearing pass
// a stalled output holds its result; the front stalls only when the queue is full
`default_nettype none

module quic_varint_codec_unit
  import qvc_pkg::*;
#(
  parameter int unsigned QueueDepth = QVC_QUEUE_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // value_in, byte_in
  input  wire logic                   s_axis_tuser,  // func
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // byte_out, value_out, encoded_length
  output logic [1:0]                  m_axis_tuser,  // kind
  output logic                        m_axis_tlast
);

  logic        full, push, job_valid, pop;
  job_t        push_job, head_job;
  kind_e       kind;
  logic [7:0]  byte_out;
  logic [61:0] value_out;
  logic [3:0]  len_out;

  qvc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .func_i    (s_axis_tuser),
    .value_i   (s_axis_tdata[63:0]),
    .byte_i    (s_axis_tdata[71:64]),
    .end_i     (s_axis_tlast),
    .full_i    (full),
    .push_o    (push),
    .job_o     (push_job)
  );

  qvc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (job_valid),
    .head_o      (head_job)
  );

  qvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .kind_o      (kind),
    .byte_o      (byte_out),
    .value_o     (value_out),
    .len_o       (len_out),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {6'd0, len_out, value_out, byte_out};

endmodule

`default_nettype wire
